[sv/ille_pkg.sv]
// Shared action codes, result status codes and state-independent types of the list engine.
`default_nettype none
package ille_pkg;

   // Action codes carried on the request channel.
   typedef logic [3:0] action_type;
   localparam action_type ACT_INSERT_AFTER = 4'd0;
   localparam action_type ACT_PUSH_FRONT   = 4'd1;
   localparam action_type ACT_PUSH_BACK    = 4'd2;
   localparam action_type ACT_DELETE       = 4'd3;
   localparam action_type ACT_POP_FRONT    = 4'd4;
   localparam action_type ACT_POP_BACK     = 4'd5;
   localparam action_type ACT_SEARCH       = 4'd6;
   localparam action_type ACT_LOCATE       = 4'd7;
   localparam action_type ACT_LINEARIZE    = 4'd8;

   // Status codes returned with every result item.
   typedef logic [1:0] status_type;
   localparam status_type STS_OK   = 2'd0;
   localparam status_type STS_BAD  = 2'd1;
   localparam status_type STS_FULL = 2'd2;
   localparam status_type STS_MISS = 2'd3;

endpackage
`default_nettype wire

[sv/ille_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ille_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 65
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[sv/indexed_linked_list_engine_core.sv]
// Top level of the slot-indexed doubly linked list engine with its free list and sequencer.
//
//   Channel  Direction  Handshake             Carries
//   req_     in         req_valid/req_stall   action, position, key, logical_index
//   rsp_     out        rsp_valid/rsp_stall   slot, key_out, status, element_count, is_linear
//   csr_     in         csr_wr_en             capacity_limit
//
// One item is worked on at a time by a sequencer around one read and one write port per store.
// Insert checks the position, fills a free slot and links both neighbours; delete and pop check,
// free and unlink the slot; locate answers at once when the list is linear, else walks from the
// head, as search does; linearize copies the keys and rewrites the stores. After reset a clearing
// pass writes the stores before the first item is taken. A waiting result does not block the next
// item; only the hand-over of the following result waits on rsp_stall.
`default_nettype none
module indexed_linked_list_engine_core #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned KEY_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_action,
   input  wire logic [6:0]  req_position,
   input  wire logic [63:0] req_key,
   input  wire logic [6:0]  req_logical_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_slot,
   output logic [63:0]      rsp_key_out,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_element_count,
   output logic             rsp_is_linear,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   localparam int unsigned SW    = $clog2(CAPACITY + 1);
   localparam int unsigned PW    = (SW > 7) ? SW : 7;
   localparam int unsigned DEPTH = CAPACITY + 1;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
   localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

   // Sequencer states.
   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_INS_CHK   = 5'd1;
   localparam logic [4:0] ST_INS_FREE  = 5'd2;
   localparam logic [4:0] ST_INS_LINKP = 5'd3;
   localparam logic [4:0] ST_INS_LINKN = 5'd4;
   localparam logic [4:0] ST_DEL_CHK   = 5'd5;
   localparam logic [4:0] ST_DEL_LINKP = 5'd6;
   localparam logic [4:0] ST_DEL_LINKN = 5'd7;
   localparam logic [4:0] ST_SRCH_ISS  = 5'd8;
   localparam logic [4:0] ST_SRCH_CMP  = 5'd9;
   localparam logic [4:0] ST_LOC_ISS   = 5'd10;
   localparam logic [4:0] ST_LOC_NXT   = 5'd11;
   localparam logic [4:0] ST_LIN_ISS   = 5'd12;
   localparam logic [4:0] ST_LIN_CPY   = 5'd13;
   localparam logic [4:0] ST_LIN_WRD   = 5'd14;
   localparam logic [4:0] ST_LIN_WR    = 5'd15;
   localparam logic [4:0] ST_FIN       = 5'd16;

   // Control state.
   logic [4:0]    state_ff, state_in;
   logic          clr_ff, clr_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [SW-1:0] free_ff, free_in;
   logic [SW-1:0] count_ff, count_in;
   logic          lin_ff, lin_in;
   logic [6:0]    limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers of the current item.
   logic [SW-1:0]       pos_ff, pos_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [6:0]          lidx_ff, lidx_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       nxt_ff, nxt_in;
   logic [SW-1:0]       prv_ff, prv_in;
   logic [SW-1:0]       res_slot_ff, res_slot_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   ille_pkg::status_type res_status_ff, res_status_in;

   // Output register.
   logic [6:0]  rsp_slot_ff, rsp_slot_in;
   logic [63:0] rsp_key_ff, rsp_key_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_lin_ff, rsp_lin_in;

   // Store ports.
   logic [SW-1:0]       rd_addr, wr_addr;
   logic                key_we, next_we, prev_we, used_we, scr_we;
   logic [KEY_BITS-1:0] key_wd, key_rd, scr_rd;
   logic [SW-1:0]       next_wd, next_rd, prev_wd, prev_rd;
   logic                used_wd, used_rd;

   logic [PW-1:0] eff_pos;
   logic [PW-1:0] limit_eff;
   logic          in_full;

   ille_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(wr_addr), .wr_data(key_wd),
      .rd_addr(rd_addr), .rd_data(key_rd));
   ille_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(wr_addr), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(next_rd));
   ille_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(wr_addr), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(prev_rd));
   ille_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_used_ram (
      .clock(clock), .wr_en(used_we), .wr_addr(wr_addr), .wr_data(used_wd),
      .rd_addr(rd_addr), .rd_data(used_rd));
   // The scratch store only ever receives keys read during the linearize walk.
   ille_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_scr_ram (
      .clock(clock), .wr_en(scr_we), .wr_addr(wr_addr), .wr_data(key_rd),
      .rd_addr(rd_addr), .rd_data(scr_rd));

   // Effective position of an insert or delete, taken from the sentinel links where implied.
   always_comb begin
      unique case (req_action) inside
         ille_pkg::ACT_INSERT_AFTER, ille_pkg::ACT_DELETE: eff_pos = PW'(req_position);
         ille_pkg::ACT_PUSH_BACK, ille_pkg::ACT_POP_BACK:   eff_pos = PW'(tail_ff);
         ille_pkg::ACT_POP_FRONT:                           eff_pos = PW'(head_ff);
         default:                                           eff_pos = '0;
      endcase
   end

   // Usable limit, clamped to 1..CAPACITY.
   always_comb begin
      limit_eff = PW'(limit_ff);
      if (limit_eff == '0) begin
         limit_eff = PW'(1);
      end
      if (limit_eff > CAP_P) begin
         limit_eff = CAP_P;
      end
   end

   assign in_full = (PW'(count_ff) >= limit_eff) || (free_ff == '0);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      lin_in        = lin_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      lidx_in       = lidx_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      nxt_in        = nxt_ff;
      prv_in        = prv_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lin_in    = rsp_lin_ff;
      rd_addr       = cur_ff;
      wr_addr       = cur_ff;
      key_we        = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      used_we       = 1'b0;
      scr_we        = 1'b0;
      key_wd        = '0;
      next_wd       = '0;
      prev_wd       = '0;
      used_wd       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = SW'(eff_pos);
            if (req_valid) begin
               pos_in        = SW'(eff_pos);
               key_in        = req_key[KEY_BITS-1:0];
               lidx_in       = req_logical_index;
               res_slot_in   = '0;
               res_key_in    = '0;
               res_status_in = ille_pkg::STS_BAD;
               state_in      = ST_FIN;
               case (req_action) inside
                  ille_pkg::ACT_INSERT_AFTER, ille_pkg::ACT_PUSH_FRONT,
                  ille_pkg::ACT_PUSH_BACK: begin
                     if (eff_pos <= CAP_P) begin
                        state_in = ST_INS_CHK;
                     end
                  end
                  ille_pkg::ACT_DELETE, ille_pkg::ACT_POP_FRONT,
                  ille_pkg::ACT_POP_BACK: begin
                     if ((eff_pos != '0) && (eff_pos <= CAP_P)) begin
                        state_in = ST_DEL_CHK;
                     end
                  end
                  ille_pkg::ACT_SEARCH: begin
                     res_status_in = ille_pkg::STS_MISS;
                     cur_in        = head_ff;
                     idx_in        = '0;
                     state_in      = ST_SRCH_ISS;
                  end
                  ille_pkg::ACT_LOCATE: begin
                     if ((req_logical_index != '0) &&
                         (PW'(req_logical_index) <= PW'(count_ff))) begin
                        if (lin_ff) begin
                           res_slot_in   = SW'(req_logical_index);
                           res_status_in = ille_pkg::STS_OK;
                        end else begin
                           cur_in   = head_ff;
                           idx_in   = SW'(1);
                           state_in = ST_LOC_ISS;
                        end
                     end
                  end
                  ille_pkg::ACT_LINEARIZE: begin
                     idx_in = SW'(1);
                     cur_in = head_ff;
                     state_in = (count_ff == '0) ? ST_LIN_WRD : ST_LIN_ISS;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         // Position checks, then fetch the link of the first free slot.
         ST_INS_CHK: begin
            rd_addr = free_ff;
            if ((pos_ff != '0) && !used_rd) begin
               state_in = ST_FIN;
            end else if (in_full) begin
               res_status_in = ille_pkg::STS_FULL;
               state_in      = ST_FIN;
            end else begin
               nxt_in   = (pos_ff == '0) ? head_ff : next_rd;
               state_in = ST_INS_FREE;
            end
         end

         // Take the free slot and fill it in.
         ST_INS_FREE: begin
            wr_addr = free_ff;
            key_we  = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            used_we = 1'b1;
            key_wd  = key_ff;
            next_wd = nxt_ff;
            prev_wd = pos_ff;
            used_wd = 1'b1;
            free_in = next_rd;
            cur_in  = free_ff;
            lin_in  = lin_ff && (pos_ff == tail_ff) &&
                      (PW'(free_ff) == PW'(count_ff) + PW'(1));
            count_in = count_ff + SW'(1);
            state_in = ST_INS_LINKP;
         end

         ST_INS_LINKP: begin
            wr_addr = pos_ff;
            next_we = 1'b1;
            next_wd = cur_ff;
            if (pos_ff == '0) begin
               head_in = cur_ff;
            end
            state_in = ST_INS_LINKN;
         end

         ST_INS_LINKN: begin
            wr_addr = nxt_ff;
            prev_we = 1'b1;
            prev_wd = cur_ff;
            if (nxt_ff == '0) begin
               tail_in = cur_ff;
            end
            res_slot_in   = cur_ff;
            res_status_in = ille_pkg::STS_OK;
            state_in      = ST_FIN;
         end

         // Check the slot, then return it to the free list.
         ST_DEL_CHK: begin
            if (!used_rd) begin
               state_in = ST_FIN;
            end else begin
               if (pos_ff != tail_ff) begin
                  lin_in = 1'b0;
               end
               res_key_in = key_rd;
               prv_in     = prev_rd;
               nxt_in     = next_rd;
               wr_addr    = pos_ff;
               key_we     = 1'b1;
               next_we    = 1'b1;
               prev_we    = 1'b1;
               used_we    = 1'b1;
               next_wd    = free_ff;
               free_in    = pos_ff;
               state_in   = ST_DEL_LINKP;
            end
         end

         ST_DEL_LINKP: begin
            wr_addr = prv_ff;
            next_we = 1'b1;
            next_wd = nxt_ff;
            if (prv_ff == '0) begin
               head_in = nxt_ff;
            end
            state_in = ST_DEL_LINKN;
         end

         ST_DEL_LINKN: begin
            wr_addr = nxt_ff;
            prev_we = 1'b1;
            prev_wd = prv_ff;
            if (nxt_ff == '0) begin
               tail_in = prv_ff;
            end
            if (count_ff != '0) begin
               count_in = count_ff - SW'(1);
            end
            res_slot_in   = pos_ff;
            res_status_in = ille_pkg::STS_OK;
            state_in      = ST_FIN;
         end

         // Key search from the head, comparing one element at a time.
         ST_SRCH_ISS: begin
            rd_addr = cur_ff;
            if ((idx_ff < count_ff) && (cur_ff != '0)) begin
               state_in = ST_SRCH_CMP;
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_SRCH_CMP: begin
            if (key_rd == key_ff) begin
               res_slot_in   = cur_ff;
               res_status_in = ille_pkg::STS_OK;
               state_in      = ST_FIN;
            end else begin
               cur_in   = next_rd;
               idx_in   = idx_ff + SW'(1);
               state_in = ST_SRCH_ISS;
            end
         end

         // Walk to the requested element when the list is not linear.
         ST_LOC_ISS: begin
            rd_addr = cur_ff;
            if (PW'(idx_ff) == PW'(lidx_ff)) begin
               res_slot_in   = cur_ff;
               res_status_in = ille_pkg::STS_OK;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_LOC_NXT;
            end
         end

         ST_LOC_NXT: begin
            cur_in   = next_rd;
            idx_in   = idx_ff + SW'(1);
            state_in = ST_LOC_ISS;
         end

         // Linearize, first pass: copy keys in list order into the scratch store.
         ST_LIN_ISS: begin
            rd_addr  = cur_ff;
            state_in = ST_LIN_CPY;
         end

         ST_LIN_CPY: begin
            wr_addr = idx_ff;
            scr_we  = 1'b1;
            cur_in  = next_rd;
            if (idx_ff == count_ff) begin
               idx_in   = SW'(1);
               state_in = ST_LIN_WRD;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_LIN_ISS;
            end
         end

         // Second pass, also the clearing pass after reset: rewrite every slot.
         ST_LIN_WRD: begin
            rd_addr  = idx_ff;
            state_in = ST_LIN_WR;
         end

         ST_LIN_WR: begin
            wr_addr = idx_ff;
            key_we  = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            used_we = 1'b1;
            if (idx_ff <= count_ff) begin
               key_wd  = scr_rd;
               next_wd = (idx_ff == count_ff) ? '0 : idx_ff + SW'(1);
               prev_wd = idx_ff - SW'(1);
               used_wd = 1'b1;
            end else begin
               next_wd = (idx_ff == CAP_S) ? '0 : idx_ff + SW'(1);
            end
            if (idx_ff == CAP_S) begin
               head_in       = (count_ff != '0) ? SW'(1) : '0;
               tail_in       = count_ff;
               free_in       = (count_ff < CAP_S) ? count_ff + SW'(1) : '0;
               lin_in        = 1'b1;
               res_status_in = ille_pkg::STS_OK;
               clr_in        = 1'b0;
               state_in      = clr_ff ? ST_IDLE : ST_FIN;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_LIN_WRD;
            end
         end

         // Hand the result to the output register once it is free.
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = 7'(res_slot_ff);
               rsp_key_in    = 64'(res_key_ff);
               rsp_status_in = res_status_ff;
               rsp_count_in  = 7'(count_ff);
               rsp_lin_in    = lin_ff;
               if (res_status_ff != ille_pkg::STS_OK) begin
                  rsp_slot_in = '0;
                  rsp_key_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LIN_WRD;
         clr_ff       <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= SW'(1);
         count_ff     <= '0;
         lin_ff       <= 1'b1;
         limit_ff     <= 7'd8;
         idx_ff       <= SW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         lin_ff       <= lin_in;
         limit_ff     <= limit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      lidx_ff       <= lidx_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      prv_ff        <= prv_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lin_ff    <= rsp_lin_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_key_out       = rsp_key_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_linear     = rsp_lin_ff;

   // An empty list has both sentinel links at zero, and only then.
   a_sentinel_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((head_ff == '0) == (tail_ff == '0)))
      else $error("sentinel head and tail disagree on an empty list");

   // The element count agrees with the head link.
   a_count_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((count_ff == '0) == (head_ff == '0)))
      else $error("element count and head link disagree");

   // While the store is not full the free list has a head.
   a_free_head: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && (count_ff < CAP_S)) |-> (free_ff != '0))
      else $error("free list empty although the store is not full");

   // A deleted slot becomes the head of the free list.
   a_delete_frees: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DEL_CHK) && used_rd) |=> (free_ff == $past(pos_ff)))
      else $error("deleted slot not returned to the free list");

endmodule
`default_nettype wire
